### hw/rtl/ttcf_pkg.sv
// Shared constants, operation codes and types for the tick timer / frequency meter.
package ttcf_pkg;

    localparam int COUNT_W    = 16;
    localparam int FREQ_W     = 20;
    localparam int AGE_W      = 10;
    localparam int OP_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNTER_WRAP = 16'd10000;
    localparam logic [FREQ_W-1:0]  REF_CLOCK_HZ = 20'd1000000;
    localparam logic [AGE_W-1:0]   AGE_LIMIT    = 10'd1000;
    localparam logic [AGE_W-1:0]   AGE_STALE    = 10'd500;

    // restoring divide: one quotient bit per step
    localparam int DIV_STEPS = FREQ_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
    localparam logic [OP_W-1:0] OP_CAPTURE  = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD_1   = 3'd2;
    localparam logic [OP_W-1:0] OP_LOAD_2   = 3'd3;
    localparam logic [OP_W-1:0] OP_RUN_1    = 3'd4;
    localparam logic [OP_W-1:0] OP_RUN_2    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_ENABLE = 2'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### hw/rtl/ttcf_div.sv
// Iterative restoring divider: REF_CLOCK_HZ divided by a 16-bit period.
module ttcf_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [ttcf_pkg::COUNT_W-1:0]       divisor,
    output ttcf_pkg::div_status_t              status,
    output logic [ttcf_pkg::FREQ_W-1:0]        quotient
);

    logic [ttcf_pkg::COUNT_W-1:0]   rem_reg, rem_next;
    logic [ttcf_pkg::COUNT_W-1:0]   dvs_reg, dvs_next;
    logic [ttcf_pkg::FREQ_W-1:0]    quo_reg, quo_next;
    logic [ttcf_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           done_reg, done_next;

    logic [ttcf_pkg::COUNT_W:0]     rem_sh;
    logic [ttcf_pkg::COUNT_W:0]     diff;
    logic                           take;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[ttcf_pkg::FREQ_W-1]};
        diff   = rem_sh - {1'b0, dvs_reg};
        take   = (rem_sh >= {1'b0, dvs_reg});

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;

        if (start)
        begin
            rem_next = '0;
            quo_next = ttcf_pkg::REF_CLOCK_HZ;
            dvs_next = divisor;
            cnt_next = ttcf_pkg::DIV_CNT_W'(ttcf_pkg::DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            // remainder stays below the divisor, so 16 bits hold it
            rem_next  = take ? diff[ttcf_pkg::COUNT_W-1:0] : rem_sh[ttcf_pkg::COUNT_W-1:0];
            quo_next  = {quo_reg[ttcf_pkg::FREQ_W-2:0], take};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == ttcf_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

### hw/rtl/tick_timers_with_capture_freq_meter.sv
// Top level: millisecond tick timers, periodic event divider and capture frequency meter.
// Flow: an accepted item is latched, applied in S_EXEC and moved to the output register in
//   S_DONE once that register is free; a completing capture with a nonzero period first waits
//   in S_DIV for the 20 one-bit steps of the divider.
// One item at a time: the next item is taken once the previous one reached the output register,
//   even while that result still waits for out_ready.
// Reset (rst_n low, asynchronous): counters 0 and running, divider 0, period 1,
//   pulse disabled, capture awaiting first stamp, frequency 0, age 1000, no result held.
module tick_timers_with_capture_freq_meter (
    input  logic                               clk,
    input  logic                               rst_n,
    // input items
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ttcf_pkg::OP_W-1:0]          operation,
    input  logic [ttcf_pkg::COUNT_W-1:0]       capture_value,
    input  logic [ttcf_pkg::COUNT_W-1:0]       load_value,
    // result items
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ttcf_pkg::COUNT_W-1:0]       first_count,
    output logic [ttcf_pkg::COUNT_W-1:0]       second_count,
    output logic [ttcf_pkg::FREQ_W-1:0]        freq_hz,
    output logic                               periodic_event,
    // configuration writes
    input  logic                               cfg_write,
    input  logic [ttcf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ttcf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,   // ready for an item
        S_EXEC,   // apply the latched item to the timer state
        S_DIV,    // wait on the divider for a new frequency
        S_DONE    // hand the result to the output register
    } state_t;

    state_t state_reg, state_next;

    // latched item
    logic [ttcf_pkg::OP_W-1:0]    op_reg;
    logic [ttcf_pkg::COUNT_W-1:0] cap_reg;
    logic [ttcf_pkg::COUNT_W-1:0] ld_reg;

    // configuration
    logic [ttcf_pkg::COUNT_W-1:0] period_cfg_reg, period_cfg_next;
    logic                         enable_reg, enable_next;

    // timer state
    logic [ttcf_pkg::COUNT_W-1:0] cnt1_reg, cnt1_next;
    logic [ttcf_pkg::COUNT_W-1:0] cnt2_reg, cnt2_next;
    logic                         run1_reg, run1_next;
    logic                         run2_reg, run2_next;
    logic [ttcf_pkg::COUNT_W-1:0] divcnt_reg, divcnt_next;
    logic                         phase_reg, phase_next;
    logic [ttcf_pkg::COUNT_W-1:0] stamp_reg, stamp_next;
    logic [ttcf_pkg::FREQ_W-1:0]  freq_reg, freq_next;
    logic [ttcf_pkg::AGE_W-1:0]   age_reg, age_next;
    logic                         pulse_reg, pulse_next;

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic [ttcf_pkg::COUNT_W-1:0] out_c1_reg, out_c1_next;
    logic [ttcf_pkg::COUNT_W-1:0] out_c2_reg, out_c2_next;
    logic [ttcf_pkg::FREQ_W-1:0]  out_freq_reg, out_freq_next;
    logic                         out_pulse_reg, out_pulse_next;

    // period and divider hookup
    logic [ttcf_pkg::COUNT_W-1:0] cap_period;
    logic [ttcf_pkg::COUNT_W-1:0] divcnt_inc;
    logic [ttcf_pkg::COUNT_W-1:0] inc1, inc2;
    logic                         div_start;
    ttcf_pkg::div_status_t        div_status;
    logic [ttcf_pkg::FREQ_W-1:0]  div_quotient;

    ttcf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (cap_period),
        .status   (div_status),
        .quotient (div_quotient)
    );

    assign in_ready = (state_reg == S_IDLE);

    // The stamp wraps at 0xFFFF rather than 0x10000, so the wrapped span is one short.
    assign cap_period = (cap_reg > stamp_reg) ? (cap_reg - stamp_reg)
                                              : (cap_reg - stamp_reg - 1'b1);

    assign div_start = (state_reg == S_EXEC) && (op_reg == ttcf_pkg::OP_CAPTURE)
                       && phase_reg && (cap_period != '0);

    assign divcnt_inc = divcnt_reg + 1'b1;
    assign inc1       = cnt1_reg + 1'b1;
    assign inc2       = cnt2_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        period_cfg_next = period_cfg_reg;
        enable_next     = enable_reg;
        cnt1_next       = cnt1_reg;
        cnt2_next       = cnt2_reg;
        run1_next       = run1_reg;
        run2_next       = run2_reg;
        divcnt_next     = divcnt_reg;
        phase_next      = phase_reg;
        stamp_next      = stamp_reg;
        freq_next       = freq_reg;
        age_next        = age_reg;
        pulse_next      = pulse_reg;
        out_valid_next  = out_valid_reg;
        out_c1_next     = out_c1_reg;
        out_c2_next     = out_c2_reg;
        out_freq_next   = out_freq_reg;
        out_pulse_next  = out_pulse_reg;

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                pulse_next = 1'b0;
                state_next = S_DONE;
                case (op_reg)
                    ttcf_pkg::OP_TICK:
                    begin
                        if (age_reg < ttcf_pkg::AGE_LIMIT)
                        begin
                            age_next = age_reg + 1'b1;
                        end
                        divcnt_next = divcnt_inc;
                        if (divcnt_inc >= period_cfg_reg)
                        begin
                            divcnt_next = '0;
                            pulse_next  = enable_reg;
                        end
                        // a wrap to 0 at 16 bits also lands on 0
                        if (run1_reg)
                        begin
                            cnt1_next = (inc1 >= ttcf_pkg::COUNTER_WRAP) ? '0 : inc1;
                        end
                        if (run2_reg)
                        begin
                            cnt2_next = (inc2 >= ttcf_pkg::COUNTER_WRAP) ? '0 : inc2;
                        end
                    end
                    ttcf_pkg::OP_CAPTURE:
                    begin
                        if (!phase_reg)
                        begin
                            stamp_next = cap_reg;
                            phase_next = 1'b1;
                        end
                        else
                        begin
                            stamp_next = '0;
                            phase_next = 1'b0;
                            if (div_start)
                            begin
                                state_next = S_DIV;
                            end
                        end
                    end
                    ttcf_pkg::OP_LOAD_1: cnt1_next = ld_reg;
                    ttcf_pkg::OP_LOAD_2: cnt2_next = ld_reg;
                    ttcf_pkg::OP_RUN_1:  run1_next = ld_reg[0];
                    ttcf_pkg::OP_RUN_2:  run2_next = ld_reg[0];
                    default:
                    begin
                        // unused codes leave the state alone
                    end
                endcase
            end

            S_DIV:
            begin
                if (div_status.done)
                begin
                    freq_next  = div_quotient;
                    age_next   = '0;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_c1_next    = cnt1_reg;
                    out_c2_next    = cnt2_reg;
                    out_freq_next  = (age_reg > ttcf_pkg::AGE_STALE) ? '0 : freq_reg;
                    out_pulse_next = pulse_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // writes must arrive only while idle; the block itself does not enforce this
        if (cfg_write)
        begin
            case (cfg_index)
                ttcf_pkg::CFG_EVENT_PERIOD:
                begin
                    period_cfg_next = (cfg_data == '0) ? ttcf_pkg::COUNT_W'(1) : cfg_data;
                    divcnt_next     = '0;
                end
                ttcf_pkg::CFG_EVENT_ENABLE:
                begin
                    enable_next = cfg_data[0];
                end
                default:
                begin
                    // no register here
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            period_cfg_reg <= ttcf_pkg::COUNT_W'(1);
            enable_reg     <= 1'b0;
            cnt1_reg       <= '0;
            cnt2_reg       <= '0;
            run1_reg       <= 1'b1;
            run2_reg       <= 1'b1;
            divcnt_reg     <= '0;
            phase_reg      <= 1'b0;
            stamp_reg      <= '0;
            freq_reg       <= '0;
            age_reg        <= ttcf_pkg::AGE_LIMIT;
            pulse_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_c1_reg     <= '0;
            out_c2_reg     <= '0;
            out_freq_reg   <= '0;
            out_pulse_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            period_cfg_reg <= period_cfg_next;
            enable_reg     <= enable_next;
            cnt1_reg       <= cnt1_next;
            cnt2_reg       <= cnt2_next;
            run1_reg       <= run1_next;
            run2_reg       <= run2_next;
            divcnt_reg     <= divcnt_next;
            phase_reg      <= phase_next;
            stamp_reg      <= stamp_next;
            freq_reg       <= freq_next;
            age_reg        <= age_next;
            pulse_reg      <= pulse_next;
            out_valid_reg  <= out_valid_next;
            out_c1_reg     <= out_c1_next;
            out_c2_reg     <= out_c2_next;
            out_freq_reg   <= out_freq_next;
            out_pulse_reg  <= out_pulse_next;
        end
    end

    // item latch
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg  <= operation;
            cap_reg <= capture_value;
            ld_reg  <= load_value;
        end
    end

    assign out_valid      = out_valid_reg;
    assign first_count    = out_c1_reg;
    assign second_count   = out_c2_reg;
    assign freq_hz        = out_freq_reg;
    assign periodic_event = out_pulse_reg;

endmodule

### hw/rtl/ttcf_checker.sv
// Port-level checks for the tick timer / frequency meter, bound to the top level.
module ttcf_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [ttcf_pkg::OP_W-1:0]          operation,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [ttcf_pkg::COUNT_W-1:0]       first_count,
    input  logic [ttcf_pkg::COUNT_W-1:0]       second_count,
    input  logic [ttcf_pkg::FREQ_W-1:0]        freq_hz,
    input  logic                               periodic_event
);

    // a held result does not change
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(first_count)
            && $stable(second_count) && $stable(freq_hz) && $stable(periodic_event))
        else $error("held result changed");

    // one item at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a second item while busy");

    // an item's result cannot be in the output register in the cycle after accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early");

    // frequency never exceeds the reference clock
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> freq_hz <= ttcf_pkg::REF_CLOCK_HZ)
        else $error("frequency out of range");

    // operation is only used at the top through the accept; keep it observed
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (operation != ttcf_pkg::OP_TICK) |=> ##2
            !(out_valid && periodic_event && !$past(out_valid, 1)))
        else $error("pulse on a non-tick item");

endmodule

bind tick_timers_with_capture_freq_meter ttcf_checker u_ttcf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .first_count    (first_count),
    .second_count   (second_count),
    .freq_hz        (freq_hz),
    .periodic_event (periodic_event)
);

### sim/testbench.sv
// Self-checking testbench for the tick timers, periodic divider and capture frequency meter.
`timescale 1ns / 100ps

module testbench;

    // Opcodes and register slots with no name in the package; the block ignores them.
    localparam logic [ttcf_pkg::OP_W-1:0]      OP_UNUSED_6 = 3'd6;
    localparam logic [ttcf_pkg::OP_W-1:0]      OP_UNUSED_7 = 3'd7;
    localparam logic [ttcf_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [ttcf_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // The second stamp wraps against this span.
    localparam int unsigned STAMP_SPAN = 32'hFFFF;
    localparam int          HOLDOFF_CYCLES = 400;
    // The slowest item is a completing capture.
    localparam int          SETTLE_CYCLES = 30;

    typedef struct packed {
        logic [ttcf_pkg::OP_W-1:0]    op;
        logic [ttcf_pkg::COUNT_W-1:0] cap;
        logic [ttcf_pkg::COUNT_W-1:0] ld;
    } meter_item_t;

    typedef struct packed {
        logic [ttcf_pkg::COUNT_W-1:0] first;
        logic [ttcf_pkg::COUNT_W-1:0] second;
        logic [ttcf_pkg::FREQ_W-1:0]  freq;
        logic                         pulse;
    } reading_t;

    // DUT ports; every input starts at a known value.
    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [ttcf_pkg::OP_W-1:0]       operation = ttcf_pkg::OP_TICK;
    logic [ttcf_pkg::COUNT_W-1:0]    capture_value = '0;
    logic [ttcf_pkg::COUNT_W-1:0]    load_value = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [ttcf_pkg::COUNT_W-1:0]    first_count;
    logic [ttcf_pkg::COUNT_W-1:0]    second_count;
    logic [ttcf_pkg::FREQ_W-1:0]     freq_hz;
    logic                            periodic_event;
    logic                            cfg_write = 1'b0;
    logic [ttcf_pkg::CFG_IDX_W-1:0]  cfg_index = ttcf_pkg::CFG_EVENT_PERIOD;
    logic [ttcf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Predicted state of the block, kept in step with accepted items and register writes.
    logic [ttcf_pkg::COUNT_W-1:0] ms_first;
    logic [ttcf_pkg::COUNT_W-1:0] ms_second;
    logic                         ms_first_on;
    logic                         ms_second_on;
    logic [ttcf_pkg::COUNT_W-1:0] div_ticks;
    logic                         stamp_pending;
    logic [ttcf_pkg::COUNT_W-1:0] stamp_first;
    logic [ttcf_pkg::FREQ_W-1:0]  freq_latched;
    logic [ttcf_pkg::AGE_W-1:0]   freq_age;
    logic [ttcf_pkg::COUNT_W-1:0] cfg_period;
    logic                         cfg_enable;

    // Items waiting for the driver, and readings waiting for the block to produce them.
    meter_item_t pending_items[$];
    reading_t    readings[$];

    // Pacing knobs, set by the sequence at phase boundaries.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        holdoff_armed = 1'b0;
    int          holdoff_count = 0;
    logic        holdoff_active;

    // Bookkeeping.
    int          items_queued = 0;
    int          results_seen = 0;
    int          failures = 0;
    int          pulses_seen = 0;
    int          live_readings = 0;
    int          pairs_done = 0;
    int          input_stalls = 0;
    int          phases_run = 0;
    logic [ttcf_pkg::COUNT_W-1:0] last_stamp = '0;

    tick_timers_with_capture_freq_meter dut (.*);

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Millisecond counter step: 16-bit increment, then back to 0 at or past the wrap value.
    function automatic logic [ttcf_pkg::COUNT_W-1:0] wrap_count(
        input logic [ttcf_pkg::COUNT_W-1:0] c);
        logic [ttcf_pkg::COUNT_W-1:0] n;
        n = c + 1'b1;
        return (n >= ttcf_pkg::COUNTER_WRAP) ? '0 : n;
    endfunction

    // Applies one item to the predicted state and returns the reading it should produce.
    function automatic reading_t step_timers(input logic [ttcf_pkg::OP_W-1:0] op,
                                             input logic [ttcf_pkg::COUNT_W-1:0] cap,
                                             input logic [ttcf_pkg::COUNT_W-1:0] ld);
        reading_t    r;
        int unsigned span;
        int unsigned hz;
        r.pulse = 1'b0;
        hz = ttcf_pkg::REF_CLOCK_HZ;
        case (op)
            ttcf_pkg::OP_TICK:
            begin
                // age saturates so a stale reading stays stale
                if (freq_age < ttcf_pkg::AGE_LIMIT)
                    freq_age = freq_age + 1'b1;
                div_ticks = div_ticks + 1'b1;
                if (div_ticks >= cfg_period)
                begin
                    div_ticks = '0;
                    r.pulse = cfg_enable;
                end
                if (ms_first_on)
                    ms_first = wrap_count(ms_first);
                if (ms_second_on)
                    ms_second = wrap_count(ms_second);
            end
            ttcf_pkg::OP_CAPTURE:
            begin
                if (!stamp_pending)
                begin
                    stamp_first = cap;
                    stamp_pending = 1'b1;
                end
                else
                begin
                    // period as the block computes it, wrap included
                    if (cap > stamp_first)
                        span = 32'(cap) - 32'(stamp_first);
                    else
                        span = STAMP_SPAN - 32'(stamp_first) + 32'(cap);
                    // zero period: the pair completes but the reading is untouched
                    if (span != 0)
                    begin
                        freq_latched = ttcf_pkg::FREQ_W'(hz / span);
                        freq_age = '0;
                    end
                    stamp_first = '0;
                    stamp_pending = 1'b0;
                    pairs_done++;
                end
            end
            ttcf_pkg::OP_LOAD_1: ms_first = ld;
            ttcf_pkg::OP_LOAD_2: ms_second = ld;
            ttcf_pkg::OP_RUN_1:  ms_first_on = ld[0];
            ttcf_pkg::OP_RUN_2:  ms_second_on = ld[0];
            default: ;
        endcase
        r.first = ms_first;
        r.second = ms_second;
        r.freq = (freq_age > ttcf_pkg::AGE_STALE) ? '0 : freq_latched;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued items; the predictor runs at each accept.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_items
        meter_item_t nxt;
        logic        offer;
        if (rst_n)
        begin
            offer = in_valid;
            if (in_valid && !in_ready)
                input_stalls++;
            if (in_valid && in_ready)
            begin
                readings.push_back(step_timers(operation, capture_value, load_value));
                offer = 1'b0;
            end
            // valid only drops after an accept, and is assigned once per edge
            if (!offer && pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_items.pop_front();
                operation <= nxt.op;
                capture_value <= nxt.cap;
                load_value <= nxt.ld;
                offer = 1'b1;
            end
            in_valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, counted here; once armed it runs out and stays done.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && holdoff_armed && holdoff_count < HOLDOFF_CYCLES)
            holdoff_count <= holdoff_count + 1;
    end

    assign holdoff_active = holdoff_armed && (holdoff_count < HOLDOFF_CYCLES);

    // ------------------------------------------------------------------
    // Monitor: compares each accepted result with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_readings
        reading_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (readings.size() == 0)
                begin
                    $error("result with nothing predicted: first_count %0d second_count %0d",
                           first_count, second_count);
                    failures++;
                end
                else
                begin
                    want = readings.pop_front();
                    if (first_count !== want.first)
                    begin
                        $error("first_count: expected %0d, got %0d", want.first, first_count);
                        failures++;
                    end
                    if (second_count !== want.second)
                    begin
                        $error("second_count: expected %0d, got %0d", want.second, second_count);
                        failures++;
                    end
                    if (freq_hz !== want.freq)
                    begin
                        $error("freq_hz: expected %0d, got %0d", want.freq, freq_hz);
                        failures++;
                    end
                    if (periodic_event !== want.pulse)
                    begin
                        $error("periodic_event: expected %0d, got %0d",
                               want.pulse, periodic_event);
                        failures++;
                    end
                    if (want.pulse)
                        pulses_seen++;
                    if (want.freq != 0)
                        live_readings++;
                    results_seen++;
                end
            end
            out_ready <= !holdoff_active && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------

    function automatic void queue_event(input logic [ttcf_pkg::OP_W-1:0] op,
                                        input logic [ttcf_pkg::COUNT_W-1:0] cap,
                                        input logic [ttcf_pkg::COUNT_W-1:0] ld);
        meter_item_t it;
        it.op = op;
        it.cap = cap;
        it.ld = ld;
        pending_items.push_back(it);
        items_queued++;
    endfunction

    // Loads favor the wrap boundary and the 16-bit extremes.
    function automatic logic [ttcf_pkg::COUNT_W-1:0] random_load();
        case ($urandom_range(4))
            0:       return '0;
            1:       return '1;
            2:       return ttcf_pkg::COUNT_W'($urandom_range(9990, 10010));
            3:       return ttcf_pkg::COUNT_W'($urandom_range(65530, 65535));
            default: return ttcf_pkg::COUNT_W'($urandom);
        endcase
    endfunction

    // Mostly ticks so counters, divider and age all move; captures cluster near
    // each other, near the stamp extremes, or anywhere.
    task automatic queue_random_events(input int n);
        logic [ttcf_pkg::OP_W-1:0]    op;
        logic [ttcf_pkg::COUNT_W-1:0] cap;
        logic [ttcf_pkg::COUNT_W-1:0] ld;
        int unsigned                  pick;
        repeat (n)
        begin
            op = ttcf_pkg::OP_TICK;
            cap = ttcf_pkg::COUNT_W'($urandom);
            ld = ttcf_pkg::COUNT_W'($urandom);
            pick = $urandom_range(99);
            if (pick < 20)
            begin
                op = ttcf_pkg::OP_CAPTURE;
                case ($urandom_range(3))
                    0: cap = last_stamp + ttcf_pkg::COUNT_W'($urandom_range(1, 40));
                    1: cap = ($urandom_range(1) != 0)
                             ? ttcf_pkg::COUNT_W'($urandom_range(15))
                             : ttcf_pkg::COUNT_W'($urandom_range(65520, 65535));
                    default: ;
                endcase
                last_stamp = cap;
            end
            else if (pick < 26)
            begin
                op = ttcf_pkg::OP_LOAD_1;
                ld = random_load();
            end
            else if (pick < 32)
            begin
                op = ttcf_pkg::OP_LOAD_2;
                ld = random_load();
            end
            else if (pick < 36)
            begin
                op = ttcf_pkg::OP_RUN_1;
                ld[0] = ($urandom_range(99) < 70);
            end
            else if (pick < 40)
            begin
                op = ttcf_pkg::OP_RUN_2;
                ld[0] = ($urandom_range(99) < 70);
            end
            else if (pick < 44)
            begin
                op = ($urandom_range(1) != 0) ? OP_UNUSED_6 : OP_UNUSED_7;
            end
            queue_event(op, cap, ld);
        end
    endtask

    // Register write; the predictor takes it at once since the block is idle.
    task automatic write_reg(input logic [ttcf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ttcf_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == ttcf_pkg::CFG_EVENT_PERIOD)
        begin
            // a zero period is stored as one
            cfg_period = (data == '0) ? ttcf_pkg::COUNT_W'(1) : data;
            div_ticks = '0;
        end
        else if (idx == ttcf_pkg::CFG_EVENT_ENABLE)
        begin
            cfg_enable = data[0];
        end
    endtask

    task automatic set_pacing(input int unsigned send_pct, input int unsigned recv_pct);
        @(posedge clk);
        send_idle_pct <= send_pct;
        recv_stall_pct <= recv_pct;
        phases_run++;
    endtask

    // Every queued item has been accepted and its result checked.
    task automatic wait_drained();
        while (results_seen != items_queued)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // predictor at its reset values
        ms_first = '0;
        ms_second = '0;
        ms_first_on = 1'b1;
        ms_second_on = 1'b1;
        div_ticks = '0;
        stamp_pending = 1'b0;
        stamp_first = '0;
        freq_latched = '0;
        freq_age = ttcf_pkg::AGE_LIMIT;
        cfg_period = ttcf_pkg::COUNT_W'(1);
        cfg_enable = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero period write, pulse on every tick.
        write_reg(ttcf_pkg::CFG_EVENT_PERIOD, '0);
        write_reg(ttcf_pkg::CFG_EVENT_ENABLE, ttcf_pkg::CFG_DATA_W'(1));
        set_pacing(0, 0);
        queue_event(ttcf_pkg::OP_TICK, 16'h0000, 16'h0000);       // age already saturated
        queue_event(ttcf_pkg::OP_CAPTURE, 16'hFFFF, 16'h0000);    // zero-period pair
        queue_event(ttcf_pkg::OP_CAPTURE, 16'h0000, 16'hFFFF);
        queue_event(ttcf_pkg::OP_CAPTURE, 16'd100, 16'h0000);     // equal stamps: full wrap
        queue_event(ttcf_pkg::OP_CAPTURE, 16'd100, 16'h0000);
        queue_event(ttcf_pkg::OP_CAPTURE, 16'd5, 16'h0000);       // period of one: top frequency
        queue_event(ttcf_pkg::OP_CAPTURE, 16'd6, 16'h0000);
        queue_event(ttcf_pkg::OP_CAPTURE, 16'h0000, 16'h0000);    // widest forward period
        queue_event(ttcf_pkg::OP_CAPTURE, 16'hFFFF, 16'h0000);
        queue_event(ttcf_pkg::OP_CAPTURE, 16'd40000, 16'h0000);   // second stamp wrapped
        queue_event(ttcf_pkg::OP_CAPTURE, 16'd1000, 16'h0000);
        queue_event(ttcf_pkg::OP_LOAD_1, 16'h0000, 16'hFFFF);     // 16-bit wrap on next tick
        queue_event(ttcf_pkg::OP_TICK, 16'hFFFF, 16'h0000);
        queue_event(ttcf_pkg::OP_LOAD_2, 16'h0000, 16'd10000);    // loaded at the wrap value
        queue_event(ttcf_pkg::OP_TICK, 16'h0000, 16'h0000);
        queue_event(ttcf_pkg::OP_LOAD_1, 16'h0000, 16'd9999);     // lands exactly on the wrap
        queue_event(ttcf_pkg::OP_TICK, 16'h0000, 16'h0000);
        queue_event(ttcf_pkg::OP_RUN_1, 16'h0000, 16'hFFFE);      // stop first, upper bits ignored
        queue_event(ttcf_pkg::OP_TICK, 16'h0000, 16'h0000);
        queue_event(ttcf_pkg::OP_RUN_1, 16'hFFFF, 16'h0001);
        queue_event(ttcf_pkg::OP_RUN_2, 16'h0000, 16'h0000);
        queue_event(ttcf_pkg::OP_TICK, 16'h0000, 16'h0000);
        queue_event(ttcf_pkg::OP_RUN_2, 16'h0000, 16'hFFFF);
        queue_event(OP_UNUSED_6, ttcf_pkg::COUNT_W'($urandom), ttcf_pkg::COUNT_W'($urandom));
        queue_event(OP_UNUSED_7, ttcf_pkg::COUNT_W'($urandom), ttcf_pkg::COUNT_W'($urandom));
        wait_drained();

        // Random, no idling on either side.
        write_reg(ttcf_pkg::CFG_EVENT_PERIOD, ttcf_pkg::CFG_DATA_W'(1));
        set_pacing(0, 0);
        queue_random_events(150);
        wait_drained();

        // Random, sender idles often.
        write_reg(ttcf_pkg::CFG_EVENT_PERIOD, ttcf_pkg::CFG_DATA_W'(3));
        set_pacing(56, 0);
        queue_random_events(150);
        wait_drained();

        // Random, receiver stalls; starts with a long hold-off so the block backs up.
        write_reg(ttcf_pkg::CFG_EVENT_PERIOD, ttcf_pkg::CFG_DATA_W'(16'hFFFF));
        write_reg(ttcf_pkg::CFG_EVENT_ENABLE, '0);
        set_pacing(0, 56);
        holdoff_armed <= 1'b1;
        queue_random_events(150);
        wait_drained();

        // Random, both sides idle.
        write_reg(ttcf_pkg::CFG_EVENT_PERIOD, ttcf_pkg::CFG_DATA_W'($urandom_range(2, 20)));
        write_reg(ttcf_pkg::CFG_EVENT_ENABLE, ttcf_pkg::CFG_DATA_W'(1));
        set_pacing(37, 37);
        queue_random_events(150);
        wait_drained();

        // Aging: one fresh 1 kHz reading, then enough ticks to cross the stale limit.
        write_reg(CFG_SPARE_2, ttcf_pkg::CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_3, '1);
        write_reg(ttcf_pkg::CFG_EVENT_PERIOD, ttcf_pkg::CFG_DATA_W'(7));
        set_pacing(37, 37);
        if (stamp_pending)
            queue_event(ttcf_pkg::OP_CAPTURE, ttcf_pkg::COUNT_W'($urandom), 16'h0000);
        queue_event(ttcf_pkg::OP_RUN_1, 16'h0000, 16'h0001);
        queue_event(ttcf_pkg::OP_CAPTURE, 16'd5, 16'h0000);
        queue_event(ttcf_pkg::OP_CAPTURE, 16'd1005, 16'h0000);
        repeat (520)
            queue_event(ttcf_pkg::OP_TICK, ttcf_pkg::COUNT_W'($urandom),
                        ttcf_pkg::COUNT_W'($urandom));
        wait_drained();

        // Random again, back to full speed.
        write_reg(ttcf_pkg::CFG_EVENT_PERIOD, ttcf_pkg::CFG_DATA_W'(2));
        set_pacing(0, 0);
        queue_random_events(150);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (readings.size() != 0)
        begin
            $error("%0d predicted readings never arrived", readings.size());
            failures++;
        end

        $display("Run covered %0d items in %0d phases: %0d capture pairs, %0d live readings,",
                 items_queued, phases_run, pairs_done, live_readings);
        $display("  %0d periodic pulses, input held back for %0d cycles.",
                 pulses_seen, input_stalls);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Timeout: %0d of %0d results checked", results_seen, items_queued);
        $display("FAIL");
        $finish;
    end

endmodule

### sim.f
hw/rtl/ttcf_pkg.sv
hw/rtl/ttcf_div.sv
hw/rtl/tick_timers_with_capture_freq_meter.sv
hw/rtl/ttcf_checker.sv
sim/testbench.sv
